[hw/rtl/rpc_pkg.sv]
// Reading plausibility checker package: codes, register indexes, payload structs.
// No dependencies.
`default_nettype none
package rpc_pkg;

    localparam int unsigned PERCENT_SCALE = 100;
    localparam int unsigned KIND_COUNT    = 5;
    localparam int unsigned KIND_W        = $clog2(KIND_COUNT);
    localparam int unsigned VALUE_W       = 16;
    localparam int unsigned TREND_W       = 7;
    localparam int unsigned RETRY_W       = 8;
    localparam int unsigned PROD_W        = 24;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [VALUE_W-1:0] CEILING_RST = 16'hFFFF;
    localparam logic [TREND_W-1:0] TREND_RST   = 7'd10;
    localparam logic [RETRY_W-1:0] RETRY_RST   = 8'd3;

    typedef enum logic [2:0] {
        CODE_OK         = 3'd0,
        CODE_ZERO       = 3'd1,
        CODE_REPEAT     = 3'd2,
        CODE_CEILING    = 3'd3,
        CODE_TREND_HIGH = 3'd4,
        CODE_TREND_LOW  = 3'd5
    } t_code;

    typedef enum logic [1:0] {
        CFG_CEILING = 2'd0,
        CFG_TREND   = 2'd1,
        CFG_RETRY   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [VALUE_W-1:0] previous_value;
        logic [VALUE_W-1:0] current_value;
        logic               history_present;
    } t_rpc_in;

    typedef struct packed {
        logic [2:0]         warning_code;
        logic               warned;
        logic [RETRY_W-1:0] retry_budget;
        logic [VALUE_W-1:0] kind_count;
    } t_rpc_out;

endpackage
`default_nettype wire

[hw/rtl/rpc_classify.sv]
// Reading classifier: zero, repeat, ceiling and trend band tests in priority order.
// Depends on rpc_pkg.
`default_nettype none
module rpc_classify (
    input  wire rpc_pkg::t_rpc_in                 i_item,
    input  wire logic [rpc_pkg::VALUE_W-1:0]      i_ceiling,
    input  wire logic [rpc_pkg::TREND_W-1:0]      i_trend,
    output rpc_pkg::t_code                        o_code
);
    import rpc_pkg::*;

    logic [TREND_W-1:0] trend_clamped;
    logic [7:0]         fac_hi;
    logic [7:0]         fac_lo;
    logic [PROD_W-1:0]  band_hi;
    logic [PROD_W-1:0]  band_lo;
    logic [PROD_W-1:0]  curr_scaled;
    logic               prev_nz;
    logic               hist;

    assign trend_clamped = (i_trend > TREND_W'(PERCENT_SCALE)) ? TREND_W'(PERCENT_SCALE)
                                                               : i_trend;
    assign fac_hi      = 8'(PERCENT_SCALE) + {1'b0, trend_clamped};
    assign fac_lo      = 8'(PERCENT_SCALE) - {1'b0, trend_clamped};
    assign band_hi     = PROD_W'(i_item.previous_value) * PROD_W'(fac_hi);
    assign band_lo     = PROD_W'(i_item.previous_value) * PROD_W'(fac_lo);
    assign curr_scaled = PROD_W'(i_item.current_value) * PROD_W'(PERCENT_SCALE);
    assign prev_nz     = (i_item.previous_value != '0);
    assign hist        = i_item.history_present;

    // floor(a/100) < c  <=>  a < 100c ; c < floor(a/100)  <=>  100c + 100 <= a
    always_comb begin
        priority if (hist && prev_nz && i_item.current_value == '0) begin
            o_code = CODE_ZERO;
        end else if (hist && prev_nz && i_item.current_value == i_item.previous_value) begin
            o_code = CODE_REPEAT;
        end else if (i_item.current_value > i_ceiling) begin
            o_code = CODE_CEILING;
        end else if (hist && band_hi < curr_scaled) begin
            o_code = CODE_TREND_HIGH;
        end else if (hist && (curr_scaled + PROD_W'(PERCENT_SCALE)) <= band_lo) begin
            o_code = CODE_TREND_LOW;
        end else begin
            o_code = CODE_OK;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rpc_counters.sv]
// Per-kind wrapping warning counters with updated count lookup.
// Depends on rpc_pkg.
`default_nettype none
module rpc_counters (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire rpc_pkg::t_code              i_code,
    output logic [rpc_pkg::VALUE_W-1:0]      o_count
);
    import rpc_pkg::*;

    logic [VALUE_W-1:0] r_cnt [KIND_COUNT];
    logic [KIND_W-1:0]  kind;
    logic               hit;
    logic [VALUE_W-1:0] cnt_inc;

    assign kind    = KIND_W'(i_code) - KIND_W'(1);
    assign hit     = (i_code != CODE_OK) && (32'(kind) < KIND_COUNT);
    assign cnt_inc = hit ? r_cnt[kind] + VALUE_W'(1) : '0;
    assign o_count = cnt_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KIND_COUNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_advance && hit) begin
            r_cnt[kind] <= cnt_inc;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/reading_plausibility_checker.sv]
// Reading plausibility checker top level: input register, classifier, counters,
// result register and configuration registers. Depends on rpc_pkg.
// Pipeline: input register, then result register; the result register loads when it is free.
// Throughput: one item per cycle unless the output stalls; each stage advances when the result register frees.
// Reset: pipeline empty, counters zero, ceiling 65535, trend 10, retry 3.
`default_nettype none
module reading_plausibility_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire rpc_pkg::t_rpc_in                  i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output rpc_pkg::t_rpc_out                      o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [rpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rpc_pkg::*;

    logic               r_s1_vld;
    t_rpc_in            r_s1_data;
    logic               r_out_vld;
    t_rpc_out           r_out_data;
    logic [VALUE_W-1:0] r_ceiling;
    logic [TREND_W-1:0] r_trend;
    logic [RETRY_W-1:0] r_retry;

    logic               out_free;
    logic               advance;
    t_code              code;
    logic [VALUE_W-1:0] kind_cnt;
    t_rpc_out           n_out_data;

    assign out_free    = !r_out_vld || i_out_ready;
    assign advance     = r_s1_vld && out_free;
    assign o_in_ready  = !r_s1_vld || out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    rpc_classify u_classify (
        .i_item    (r_s1_data),
        .i_ceiling (r_ceiling),
        .i_trend   (r_trend),
        .o_code    (code)
    );

    rpc_counters u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_code    (code),
        .o_count   (kind_cnt)
    );

    always_comb begin
        n_out_data.warning_code = code;
        n_out_data.warned       = (code != CODE_OK);
        n_out_data.retry_budget = (code != CODE_OK) ? r_retry : '0;
        n_out_data.kind_count   = kind_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= CEILING_RST;
            r_trend   <= TREND_RST;
            r_retry   <= RETRY_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CEILING: r_ceiling <= i_cfg_data;
                CFG_TREND:   r_trend   <= i_cfg_data[TREND_W-1:0];
                CFG_RETRY:   r_retry   <= i_cfg_data[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire
